// ----- rtl/psb_pkg.sv -----
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and constants for the palette sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package psb_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int MAX_DIMENSION   = 1024;
    localparam int DIM_W           = $clog2(MAX_DIMENSION);
    localparam int OFF_W           = DIM_W + 1;
    localparam int COORD_W         = DIM_W + 2;
    localparam int IDX_W           = 4;
    localparam int COLOR_W         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = OFF_W;
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    typedef enum logic {
        CMD_PALETTE_WRITE = 1'b0,
        CMD_PIXEL         = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_DEST_WIDTH    = 3'd2,
        REG_DEST_HEIGHT   = 3'd3,
        REG_OFFSET_X      = 3'd4,
        REG_OFFSET_Y      = 3'd5
    } t_reg_idx;

    // One classified word between front and back.
    typedef struct packed {
        t_cmd               cmd;
        logic               hit;      // index lies inside the palette
        logic               vis;      // pixel survives clipping and transparency
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] color;
        logic [DIM_W-1:0]   dx;
        logic [DIM_W-1:0]   dy;
        logic               last;
    } t_qent;

    typedef struct packed {
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic             pix_last;   // current pixel closes the sprite
    } t_fstat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// ----- rtl/psb_ifs.sv -----
// ----------------------------------------------------------------------------
// psb_ifs
// Handshake channels of the palette sprite blitter: pixel/command input,
// result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface psb_pix_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [psb_pkg::IDX_W-1:0]  pixel_index;
    logic [psb_pkg::COLOR_W-1:0] entry_color;

    modport source(output valid, output command, output pixel_index,
                   output entry_color, input ready);
    modport sink(input valid, input command, input pixel_index,
                 input entry_color, output ready);
endinterface

interface psb_res_if;
    logic                        valid;
    logic                        ready;
    logic                        write_enable;
    logic [psb_pkg::DIM_W-1:0]   dest_x;
    logic [psb_pkg::DIM_W-1:0]   dest_y;
    logic [psb_pkg::COLOR_W-1:0] color;
    logic                        last;

    modport source(output valid, output write_enable, output dest_x, output dest_y,
                   output color, output last, input ready);
    modport sink(input valid, input write_enable, input dest_x, input dest_y,
                 input color, input last, output ready);
endinterface

interface psb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psb_pkg::CFG_IDX_W-1:0]  index;
    logic [psb_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/psb_front.sv -----
// ----------------------------------------------------------------------------
// psb_front
// Accepts commands, holds the registers and the raster counters, computes
// the destination coordinate and clips it, and pushes one classified word.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_front import psb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    psb_pix_if.sink i_pix,
    psb_cfg_if.sink i_cfg,
    input  logic    i_full,
    output logic    o_push,
    output t_qent   o_entry,
    output t_fstat  o_stat
);

    logic [DIM_W-1:0]       r_src_w;
    logic [DIM_W-1:0]       r_src_h;
    logic [DIM_W-1:0]       r_dst_w;
    logic [DIM_W-1:0]       r_dst_h;
    logic [OFF_W-1:0]       r_off_x;
    logic [OFF_W-1:0]       r_off_y;
    logic [DIM_W-1:0]       r_col;
    logic [DIM_W-1:0]       r_row;

    logic [DIM_W:0]         col_inc;
    logic [DIM_W:0]         row_inc;
    logic                   col_end;
    logic                   row_end;
    logic [COORD_W-1:0]     dx;
    logic [COORD_W-1:0]     dy;
    logic                   x_ok;
    logic                   y_ok;
    logic                   hit;
    logic                   pix_acc;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;
    assign pix_acc     = o_push && (t_cmd'(i_pix.command) == CMD_PIXEL);

    always_comb begin
        col_inc = {1'b0, r_col} + (DIM_W+1)'(1);
        row_inc = {1'b0, r_row} + (DIM_W+1)'(1);
        col_end = col_inc >= {1'b0, r_src_w};
        row_end = row_inc >= {1'b0, r_src_h};
        // sign-extend the offset, zero-extend the counter
        dx   = {2'b00, r_col} + {r_off_x[OFF_W-1], r_off_x};
        dy   = {2'b00, r_row} + {r_off_y[OFF_W-1], r_off_y};
        x_ok = !dx[COORD_W-1] && (dx[COORD_W-2:0] < {1'b0, r_dst_w});
        y_ok = !dy[COORD_W-1] && (dy[COORD_W-2:0] < {1'b0, r_dst_h});
        hit  = 32'(i_pix.pixel_index) < PALETTE_ENTRIES;

        o_entry.cmd         = t_cmd'(i_pix.command);
        o_entry.hit         = hit;
        o_entry.vis         = hit && (i_pix.pixel_index != '0) && x_ok && y_ok;
        o_entry.pixel_index = i_pix.pixel_index;
        o_entry.color       = i_pix.entry_color;
        o_entry.dx          = dx[DIM_W-1:0];
        o_entry.dy          = dy[DIM_W-1:0];
        o_entry.last        = col_end && row_end;

        o_stat.col      = r_col;
        o_stat.row      = r_row;
        o_stat.pix_last = col_end && row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_W'(1);
            r_src_h <= DIM_W'(1);
            r_dst_w <= DIM_W'(1);
            r_dst_h <= DIM_W'(1);
            r_off_x <= '0;
            r_off_y <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SOURCE_WIDTH:  r_src_w <= i_cfg.data[DIM_W-1:0];
                REG_SOURCE_HEIGHT: r_src_h <= i_cfg.data[DIM_W-1:0];
                REG_DEST_WIDTH:    r_dst_w <= i_cfg.data[DIM_W-1:0];
                REG_DEST_HEIGHT:   r_dst_h <= i_cfg.data[DIM_W-1:0];
                REG_OFFSET_X:      r_off_x <= i_cfg.data[OFF_W-1:0];
                REG_OFFSET_Y:      r_off_y <= i_cfg.data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the raster position; wrap on the last column and last row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : row_inc[DIM_W-1:0];
            end else begin
                r_col <= col_inc[DIM_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psb_fifo.sv -----
// ----------------------------------------------------------------------------
// psb_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_fifo import psb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_entry,
    input  logic   i_pop,
    output t_qent  o_entry,
    output t_qstat o_stat
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_entry      = r_mem[r_rd];
    assign o_stat.full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == QDEPTH - 1) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (32'(r_rd) == QDEPTH - 1) ? '0 : r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psb_back.sv -----
// ----------------------------------------------------------------------------
// psb_back
// Owns the palette: applies palette writes in order and turns pixel words
// into registered result words.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_back import psb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qent     i_entry,
    input  logic      i_empty,
    output logic      o_pop,
    psb_res_if.source o_res
);

    logic [COLOR_W-1:0] r_pal [PALETTE_ENTRIES];
    logic               r_valid;
    logic               r_we;
    logic [DIM_W-1:0]   r_x;
    logic [DIM_W-1:0]   r_y;
    logic [COLOR_W-1:0] r_color;
    logic               r_last;
    logic [PAL_AW-1:0]  addr;
    logic               is_pix;

    assign addr   = i_entry.pixel_index[PAL_AW-1:0];
    assign is_pix = i_entry.cmd == CMD_PIXEL;
    // pop whenever the output register is free or being emptied
    assign o_pop  = !i_empty && (!r_valid || o_res.ready);

    assign o_res.valid        = r_valid;
    assign o_res.write_enable = r_we;
    assign o_res.dest_x       = r_x;
    assign o_res.dest_y       = r_y;
    assign o_res.color        = r_color;
    assign o_res.last         = r_last;

    always_ff @(posedge i_clk) begin
        if (o_pop && !is_pix && i_entry.hit) begin
            r_pal[addr] <= i_entry.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= is_pix;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Zero the coordinate and color fields of a word that writes nothing.
    always_ff @(posedge i_clk) begin
        if (o_pop && is_pix) begin
            r_we    <= i_entry.vis;
            r_x     <= i_entry.vis ? i_entry.dx : '0;
            r_y     <= i_entry.vis ? i_entry.dy : '0;
            r_color <= i_entry.vis ? r_pal[addr] : '0;
            r_last  <= i_entry.last;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/palette_sprite_blit_clipped.sv -----
// ----------------------------------------------------------------------------
// palette_sprite_blit_clipped
// Sprite blitter: raster-order palette indices in, clipped destination
// writes out, with a 16-entry palette loaded by command.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  i_pix    in   valid/ready          command, pixel_index, entry_color
//  i_cfg    in   valid/ready (ready=1) index, data
//  o_res    out  valid/ready          write_enable, dest_x, dest_y, color, last
//
//  One word per cycle sustained while o_res does not stall; a pixel result
//  passes through the queue and then the output register before it is valid.
//  Palette writes take one queue slot and give no result.
//  Reset is synchronous; the palette holds garbage until written.
//  A stall on o_res fills the two-word queue, then i_pix.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_sprite_blit_clipped import psb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psb_pix_if.sink   i_pix,
    psb_cfg_if.sink   i_cfg,
    psb_res_if.source o_res
);

    logic   push;
    logic   pop;
    t_qent  f_entry;
    t_qent  q_entry;
    t_qstat q_stat;
    t_fstat f_stat;
    logic   pix_acc;

    psb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .i_full  (q_stat.full),
        .o_push  (push),
        .o_entry (f_entry),
        .o_stat  (f_stat)
    );

    psb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_stat  (q_stat)
    );

    psb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_entry),
        .i_empty (q_stat.empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    assign pix_acc = i_pix.valid && i_pix.ready && i_pix.command;

    a_blank_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.write_enable) |->
        (o_res.dest_x == '0 && o_res.dest_y == '0 && o_res.color == '0))
        else $error("result without write carries nonzero fields");

    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_sprite_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && f_stat.pix_last) |=> (f_stat.col == '0 && f_stat.row == '0))
        else $error("raster counters did not wrap after last pixel");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(pop))
        else $error("result appeared without a queue pop");

endmodule

`default_nettype wire

// ----- test/tb_palette_sprite_blit_clipped.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_sprite_blit_clipped
// Self-checking bench for the sprite blitter. Palette loads and pixel words
// stream through the input channel while an in-bench blitter model walks the
// sprite raster, clips against the destination and predicts every write.
// Register setups change between phases, with sender gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_palette_sprite_blit_clipped;
    import psb_pkg::*;

    typedef struct {
        t_cmd               cmd;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
    } t_pix_word;

    typedef struct {
        logic               we;
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_blit_write;

    typedef struct {
        t_reg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psb_pix_if pix();
    psb_cfg_if cfg();
    psb_res_if res();

    palette_sprite_blit_clipped uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // blitter model state
    logic [COLOR_W-1:0]         pal [PALETTE_ENTRIES];
    logic [DIM_W-1:0]           col_pos = '0;
    logic [DIM_W-1:0]           row_pos = '0;
    logic [DIM_W-1:0]           src_w = DIM_W'(1), src_h = DIM_W'(1);
    logic [DIM_W-1:0]           dst_w = DIM_W'(1), dst_h = DIM_W'(1);
    logic signed [OFF_W-1:0]    off_x = '0, off_y = '0;

    t_pix_word   pix_pending[$];
    t_reg_write  reg_pending[$];
    t_blit_write exp_writes[$];
    t_pix_word   word_on_bus;
    t_reg_write  reg_on_bus;

    // index 0 never reads the palette
    logic [PALETTE_ENTRIES-1:0] pal_loaded = PALETTE_ENTRIES'(1);
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_errors      = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // blitter model
    // ------------------------------------------------------------------------
    function automatic void predict_blit(t_pix_word w);
        int          dx, dy;
        logic        vis, col_end, row_end;
        t_blit_write r;
        if (w.cmd == CMD_PALETTE_WRITE) begin
            pal[w.idx] = w.color;
            return;
        end
        dx = int'(col_pos) + int'(off_x);
        dy = int'(row_pos) + int'(off_y);
        vis = (w.idx != 0) && dx >= 0 && dx < int'(dst_w) && dy >= 0 && dy < int'(dst_h);
        col_end = int'(col_pos) + 1 >= int'(src_w);
        row_end = int'(row_pos) + 1 >= int'(src_h);
        r.we    = vis;
        r.x     = vis ? dx[DIM_W-1:0] : '0;
        r.y     = vis ? dy[DIM_W-1:0] : '0;
        r.color = vis ? pal[w.idx] : '0;
        r.last  = col_end && row_end;
        exp_writes.push_back(r);
        // advance raster position; a shrunk size wraps at once
        if (col_end) begin
            col_pos = '0;
            row_pos = row_end ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic void apply_reg(t_reg_write w);
        case (w.idx)
            REG_SOURCE_WIDTH:  src_w = w.data[DIM_W-1:0];
            REG_SOURCE_HEIGHT: src_h = w.data[DIM_W-1:0];
            REG_DEST_WIDTH:    dst_w = w.data[DIM_W-1:0];
            REG_DEST_HEIGHT:   dst_h = w.data[DIM_W-1:0];
            REG_OFFSET_X:      off_x = signed'(w.data[OFF_W-1:0]);
            REG_OFFSET_Y:      off_y = signed'(w.data[OFF_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic void check_write();
        t_blit_write got, want;
        got.we    = res.write_enable;
        got.x     = res.dest_x;
        got.y     = res.dest_y;
        got.color = res.color;
        got.last  = res.last;
        if (exp_writes.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: unexpected result we=%0b x=%0d y=%0d color=%h last=%0b",
                         $realtime, got.we, got.x, got.y, got.color, got.last);
            return;
        end
        want = exp_writes.pop_front();
        if (got.we !== want.we || got.x !== want.x || got.y !== want.y ||
            got.color !== want.color || got.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: mismatch exp we=%0b x=%0d y=%0d color=%h last=%0b, ",
                         $realtime, want.we, want.x, want.y, want.color, want.last,
                         "got we=%0b x=%0d y=%0d color=%h last=%0b",
                         got.we, got.x, got.y, got.color, got.last);
        end
    endfunction

    // ------------------------------------------------------------------------
    // pixel driver, register driver, result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else begin
            if (pix.valid && pix.ready) begin
                predict_blit(word_on_bus);
            end
            if (!pix.valid || pix.ready) begin
                if (pix_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_on_bus = pix_pending.pop_front();
                    pix.valid       <= 1'b1;
                    pix.command     <= word_on_bus.cmd;
                    pix.pixel_index <= word_on_bus.idx;
                    pix.entry_color <= word_on_bus.color;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.valid <= 1'b0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                apply_reg(reg_on_bus);
            end
            if (!cfg.valid || cfg.ready) begin
                if (reg_pending.size() != 0) begin
                    reg_on_bus = reg_pending.pop_front();
                    cfg.valid <= 1'b1;
                    cfg.index <= reg_on_bus.idx;
                    cfg.data  <= reg_on_bus.data;
                end else begin
                    cfg.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                check_write();
            end
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pix_pending.size() != 0 || pix.valid || exp_writes.size() != 0 ||
               reg_pending.size() != 0 || cfg.valid);
        // palette loads leave no result; let the pipeline empty out
        repeat (6) @(negedge i_clk);
    endtask

    task automatic program_setup(input logic [CFG_DATA_W-1:0] sw,
                                 input logic [CFG_DATA_W-1:0] sh,
                                 input logic [CFG_DATA_W-1:0] dw,
                                 input logic [CFG_DATA_W-1:0] dh,
                                 input logic [CFG_DATA_W-1:0] ox,
                                 input logic [CFG_DATA_W-1:0] oy);
        reg_pending.push_back('{REG_SOURCE_WIDTH, sw});
        reg_pending.push_back('{REG_SOURCE_HEIGHT, sh});
        reg_pending.push_back('{REG_DEST_WIDTH, dw});
        reg_pending.push_back('{REG_DEST_HEIGHT, dh});
        reg_pending.push_back('{REG_OFFSET_X, ox});
        reg_pending.push_back('{REG_OFFSET_Y, oy});
        do
            @(negedge i_clk);
        while (reg_pending.size() != 0 || cfg.valid);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_size(int small_max);
        int          pick;
        logic [DIM_W-1:0] s;
        pick = $urandom_range(9);
        if (pick < 7)
            s = DIM_W'($urandom_range(small_max, 1));
        else if (pick == 7)
            s = '0;
        else
            s = DIM_W'($urandom_range(MAX_DIMENSION - 1));
        // the top data bit is ignored for size registers
        return {($urandom_range(3) == 0), s};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_offset(logic [CFG_DATA_W-1:0] dim);
        int t;
        case ($urandom_range(2))
            0:       t = int'($urandom_range(12)) - 4;
            1:       t = int'(dim[DIM_W-1:0]) - int'($urandom_range(8));
            default: t = int'($urandom);
        endcase
        return t[CFG_DATA_W-1:0];
    endfunction

    task automatic program_random_setup();
        logic [CFG_DATA_W-1:0] sw, sh, dw, dh;
        sw = rand_size(8);
        sh = rand_size(6);
        dw = rand_size(16);
        dh = rand_size(16);
        program_setup(sw, sh, dw, dh, rand_offset(dw), rand_offset(dh));
    endtask

    function automatic void push_pixel(logic [IDX_W-1:0] idx);
        pix_pending.push_back('{CMD_PIXEL, idx, COLOR_W'($urandom)});
    endfunction

    function automatic void push_load(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color);
        pix_pending.push_back('{CMD_PALETTE_WRITE, idx, color});
        pal_loaded[idx] = 1'b1;
    endfunction

    function automatic void push_random_words(int n);
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 15) begin
                push_load(IDX_W'($urandom), COLOR_W'($urandom));
            end else begin
                // only read entries that hold a color
                idx = IDX_W'($urandom);
                while (!pal_loaded[idx])
                    idx = IDX_W'($urandom);
                push_pixel(idx);
            end
        end
    endfunction

    initial begin
        int n_words;
        logic [IDX_W-1:0] sweep [4];
        sweep = '{4'd15, 4'd1, 4'd0, 4'd2};
        i_rst_n         = 1'b0;
        pix.valid       = 1'b0;
        pix.command     = CMD_PIXEL;
        pix.pixel_index = '0;
        pix.entry_color = '0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_SOURCE_WIDTH;
        cfg.data        = '0;
        res.ready       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setup: one-pixel sprite, transparent pixels
        push_pixel(4'd0);
        push_pixel(4'd0);
        wait_idle();

        // 4x3 sprite one column left of the edge on a 2x2 target: clip on
        // the zero edge, the right edge and the bottom
        program_setup(11'd4, 11'd3, 11'd2, 11'd2, 11'h7FF, 11'd0);
        push_load(4'd0, 16'hFFFF);
        push_load(4'd15, 16'hFFFF);
        push_load(4'd1, 16'h0000);
        push_load(4'd2, 16'hA5A5);
        for (int k = 0; k < 13; k++)
            push_pixel(sweep[k % 4]);
        wait_idle();

        for (int p = 0; p < 14; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            case (p)
                // zero sizes, bottom-right corner of the largest target
                3:  program_setup(11'd0, 11'd0, 11'd1023, 11'd1023, 11'd1022, 11'd1022);
                // widest sprite, everything pushed off the right edge and above the top
                7:  program_setup(11'd1023, 11'd1023, 11'd1023, 11'd1023, 11'd1023, 11'h400);
                // tallest column reaching the last target row
                11: program_setup(11'd1, 11'd1023, 11'd1, 11'd1023, 11'd0, 11'd900);
                default: program_random_setup();
            endcase
            n_words = $urandom_range(150, 110);
            if (p == 5) begin
                // hold the sender until every write is back
                push_random_words(n_words / 2);
                wait_idle();
                push_random_words(n_words - n_words / 2);
            end else begin
                push_random_words(n_words);
            end
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
